@@ design/tplc_pkg.sv @@
`default_nettype none
package tplc_pkg;

   localparam int KEY_W = 31;
   localparam int VALUE_W = 31;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   // One cache entry as held by a cell of the recency chain.
   typedef struct packed {
      logic               valid;
      logic               high;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Broadcast from the controller to every cell on an update cycle.
   typedef struct packed {
      logic      update;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ design/tplc_ifc.sv @@
`default_nettype none
interface tplc_req_if;
   import tplc_pkg::*;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [KEY_W-1:0]   key;
   logic [VALUE_W-1:0] value;
   logic               priority_req;

   modport source (output valid, cmd, key, value, priority_req, input ready);
   modport sink (input valid, cmd, key, value, priority_req, output ready);
endinterface

interface tplc_rsp_if;
   import tplc_pkg::*;
   logic               valid;
   logic               ready;
   logic               hit;
   logic [VALUE_W-1:0] read_value;
   logic               evicted;
   logic [KEY_W-1:0]   evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

@@ design/tplc_cell.sv @@
`default_nettype none
module tplc_cell
   import tplc_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_ctrl_type      ctrl,
   input  wire logic [IDX_W-1:0]   src_pos,
   input  wire logic [IDX_W-1:0]   dst_pos,
   input  wire entry_type          left_entry,
   input  wire entry_type          right_entry,
   input  wire logic [KEY_W-1:0]   lookup_key,
   output entry_type               entry_out,
   output logic                    match
);

   localparam logic [IDX_W-1:0] MY_POS = IDX_W'(INDEX);

   entry_type entry_ff;
   entry_type entry_in;

   // The moved entry lands at dst_pos; the cells between it and src_pos
   // close the gap by taking their neighbour's entry.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.update) begin
         if (MY_POS == dst_pos) begin
            entry_in = ctrl.new_entry;
         end else if (MY_POS > dst_pos && MY_POS <= src_pos) begin
            entry_in = left_entry;
         end else if (MY_POS >= src_pos && MY_POS < dst_pos) begin
            entry_in = right_entry;
         end
      end
   end

   // Only the valid bit is cleared by reset; the payload is don't-care
   // while the cell is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.high  <= entry_in.high;
      entry_ff.key   <= entry_in.key;
      entry_ff.value <= entry_in.value;
   end

   assign entry_out = entry_ff;
   assign match     = entry_ff.valid && (entry_ff.key == lookup_key);

endmodule
`default_nettype wire

@@ design/two_priority_lru_cache.sv @@
// Channel  | Direction | Payload                               | Handshake
// req_chan | in        | cmd, key, value, priority_req         | valid / ready
// rsp_chan | out       | hit, read_value, evicted, evicted_key | valid / ready
//
// Each request is handled in two steps: the accepting edge compares the key against
// every cell of the chain, and the edge that leaves ST_UPDATE moves the entries.
// No new request is taken until the recency chain has moved the entries of the last one.
// Reset is synchronous and empties the cache at once; no clearing pass.
// A response waiting on rsp_chan holds the update of the next request back.
`default_nettype none
module two_priority_lru_cache
   import tplc_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   tplc_req_if.sink   req_chan,
   tplc_rsp_if.source rsp_chan
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;

   // The request is captured at acceptance, together with the match vector.
   logic               req_cmd_ff;
   logic [KEY_W-1:0]   req_key_ff;
   logic [VALUE_W-1:0] req_value_ff;
   logic               req_prio_ff;
   logic [CAPACITY-1:0] match_ff;

   // Entry count and the length of the high-priority segment at the head.
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] high_cnt_ff, high_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_evicted_ff;
   logic [KEY_W-1:0]   rsp_evicted_key_ff;

   entry_type           chain [CAPACITY];
   logic [CAPACITY-1:0] match_now;

   logic req_accept;
   logic update_fire;

   cell_ctrl_type      cell_ctrl;
   logic [IDX_W-1:0]   src_pos;
   logic [IDX_W-1:0]   dst_pos;
   logic [IDX_W-1:0]   match_idx;
   logic               any_match;
   logic [VALUE_W-1:0] match_value;
   logic               match_high;
   logic               full;
   logic               tail_high;
   logic               insert_new;
   logic [CNT_W-1:0]   high_after;

   // The recency chain: position 0 is the head of the list.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e, right_e;
      if (i == 0) begin : g_head
         assign left_e = '0;
      end else begin : g_mid_l
         assign left_e = chain[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = chain[i+1];
      end
      tplc_cell #(
         .IDX_W(IDX_W),
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .src_pos    (src_pos),
         .dst_pos    (dst_pos),
         .left_entry (left_e),
         .right_entry(right_e),
         .lookup_key (req_chan.key),
         .entry_out  (chain[i]),
         .match      (match_now[i])
      );
   end

   assign req_accept  = req_chan.valid && req_chan.ready;
   assign update_fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_accept) state_in = ST_UPDATE;
         ST_UPDATE: if (update_fire) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_UPDATE: req_chan.ready = 1'b0;
         default:   req_chan.ready = 1'b0;
      endcase
   end

   // Keys are unique in the cache, so the match vector is at most one-hot and
   // the selected fields can be gathered by OR.
   always_comb begin
      match_idx   = '0;
      match_value = '0;
      match_high  = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_ff[i]) begin
            match_idx   = match_idx | IDX_W'(i);
            match_value = match_value | chain[i].value;
            match_high  = match_high | chain[i].high;
         end
      end
   end

   assign any_match  = |match_ff;
   assign full       = (fill_ff == CNT_W'(CAPACITY));
   assign tail_high  = chain[CAPACITY-1].high;
   assign insert_new = (req_cmd_ff == CMD_INSERT) && !any_match;

   // Work out where the touched entry comes from and where it goes. A hit
   // vacates its own position; a new insert takes the first free position or,
   // when the cache is full, the tail, which is evicted.
   always_comb begin
      high_after = high_cnt_ff;
      if (any_match) begin
         src_pos = match_idx;
         if (req_cmd_ff == CMD_INSERT) begin
            high_after = high_cnt_ff - CNT_W'(match_high);
         end
      end else if (full) begin
         src_pos    = IDX_W'(CAPACITY - 1);
         high_after = high_cnt_ff - CNT_W'(tail_high);
      end else begin
         src_pos = fill_ff[IDX_W-1:0];
      end

      if (req_cmd_ff == CMD_LOOKUP) begin
         dst_pos = match_high ? '0 : high_cnt_ff[IDX_W-1:0];
      end else begin
         dst_pos = req_prio_ff ? '0 : high_after[IDX_W-1:0];
      end

      cell_ctrl.update          = update_fire && ((req_cmd_ff == CMD_INSERT) || any_match);
      cell_ctrl.new_entry.valid = 1'b1;
      cell_ctrl.new_entry.key   = req_key_ff;
      if (req_cmd_ff == CMD_LOOKUP) begin
         cell_ctrl.new_entry.high  = match_high;
         cell_ctrl.new_entry.value = match_value;
      end else begin
         cell_ctrl.new_entry.high  = req_prio_ff;
         cell_ctrl.new_entry.value = req_value_ff;
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      high_cnt_in = high_cnt_ff;
      if (update_fire && (req_cmd_ff == CMD_INSERT)) begin
         high_cnt_in = high_after + CNT_W'(req_prio_ff);
         if (insert_new && !full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         high_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         high_cnt_ff  <= high_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_cmd_ff   <= req_chan.cmd;
         req_key_ff   <= req_chan.key;
         req_value_ff <= req_chan.value;
         req_prio_ff  <= req_chan.priority_req;
         match_ff     <= match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire) begin
         rsp_hit_ff         <= any_match;
         rsp_value_ff       <= (req_cmd_ff == CMD_LOOKUP && any_match) ? match_value : '0;
         rsp_evicted_ff     <= insert_new && full;
         rsp_evicted_key_ff <= (insert_new && full) ? chain[CAPACITY-1].key : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.read_value  = rsp_value_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_key = rsp_evicted_key_ff;

   // The cache never holds more entries than it has cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // The high segment is part of the list.
   a_high_bound: assert property (@(posedge clock) disable iff (reset)
      high_cnt_ff <= fill_ff)
      else $error("high segment longer than list");

   // A key is held in at most one cell.
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> $onehot0(match_ff))
      else $error("key matched in more than one cell");

   // A new key inserted below capacity grows the list by one entry.
   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (update_fire && insert_new && !full) |=> (fill_ff == $past(fill_ff) + CNT_W'(1)))
      else $error("entry count did not grow on insert");

   // Eviction is reported only for an insert of a key that was absent.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evicted_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the two-segment priority LRU cache.
//
// The cache is treated as a black box behind two valid/ready channels. Every
// request that the cache accepts is fed to a predictor that keeps its own copy
// of the recency list. The predicted response is queued, and each response
// that leaves the cache is compared with the oldest queued prediction.
//
// The stimulus runs as a sequence of test tasks. A short directed test covers
// the corner cases. A fill test drives the list into a state with no
// low-priority entries and then evicts high ones. A pressure test holds the
// receiver off for a long stretch while requests keep coming. Four random
// phases finish the run, each with its own idling profile.
module tb_top;
   import tplc_pkg::*;

   localparam int CACHE_DEPTH = 64;
   localparam int RESET_CYCLES = 10;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRESSURE_HOLD = 300;
   localparam int TAIL_CYCLES = 12;
   localparam int KEY_POOL_SIZE = 100;
   localparam int REPORT_LIMIT = 10;
   localparam logic [KEY_W-1:0] KEY_MAX = '1;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   // One entry of the predicted recency list, head first.
   typedef struct {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               high;
   } cache_line_type;

   // What the cache is expected to answer for one request.
   typedef struct {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
      logic [KEY_W-1:0]   evicted_key;
   } access_result_type;

   logic clock = 1'b0;
   logic reset;

   tplc_req_if req_bus ();
   tplc_rsp_if rsp_bus ();

   two_priority_lru_cache #(
      .CAPACITY(CACHE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus.sink),
      .rsp_chan(rsp_bus.source)
   );

   always #10 clock = ~clock;

   // Predicted contents of the cache and the responses still owed by it.
   cache_line_type    recency_list[$];
   access_result_type pending_results[$];

   // Idling profile, in percent of cycles, set by each test.
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;

   logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

   int unsigned error_count = 0;
   int unsigned insert_count = 0;
   int unsigned lookup_count = 0;
   int unsigned hit_count = 0;
   int unsigned eviction_count = 0;
   int unsigned quiet_cycles = 0;

   logic holding = 1'b0;
   event start_hold;

   // Places an entry at the front of its own segment. High entries all stand
   // ahead of low ones, so the front of the low segment is the number of
   // high entries in the list.
   function automatic void place_line(cache_line_type line);
      int unsigned slot_pos;
      slot_pos = 0;
      if (!line.high) begin
         foreach (recency_list[i]) begin
            if (recency_list[i].high) slot_pos++;
         end
      end
      if (slot_pos == recency_list.size()) recency_list.push_back(line);
      else recency_list.insert(slot_pos, line);
   endfunction

   // Works out the response to one accepted request and updates the
   // predicted list. Keys in the list are unique, since an insert of a key
   // already present updates and moves that entry instead of adding one.
   function automatic access_result_type predict_cache_access(
      logic cmd, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value, logic prio);
      access_result_type result;
      cache_line_type    line;
      int                found;
      result = '{hit: 1'b0, read_value: '0, evicted: 1'b0, evicted_key: '0};
      found = -1;
      foreach (recency_list[i]) begin
         if (recency_list[i].key == key) found = i;
      end
      if (found >= 0) begin
         line = recency_list[found];
         result.hit = 1'b1;
         if (cmd == CMD_LOOKUP) begin
            result.read_value = line.value;
         end else begin
            line.value = value;
            line.high = prio;
         end
         recency_list.delete(found);
         place_line(line);
      end else if (cmd == CMD_INSERT) begin
         // A full cache gives up its tail: the last low entry, or the last
         // high entry when the low segment is empty.
         if (recency_list.size() == CACHE_DEPTH) begin
            result.evicted = 1'b1;
            result.evicted_key = recency_list[$].key;
            void'(recency_list.pop_back());
         end
         line = '{key: key, value: value, high: prio};
         place_line(line);
      end
      return result;
   endfunction

   // Response checking comes first and request prediction second within the
   // same edge, so a response is never matched against its own request.
   always @(posedge clock) begin : monitor
      access_result_type got;
      access_result_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{hit: rsp_bus.hit, read_value: rsp_bus.read_value,
                    evicted: rsp_bus.evicted, evicted_key: rsp_bus.evicted_key};
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%t: response with no request outstanding: hit %b value %h",
                           $realtime, got.hit, got.read_value);
            end else begin
               want = pending_results.pop_front();
               if (got.hit !== want.hit || got.read_value !== want.read_value ||
                   got.evicted !== want.evicted ||
                   got.evicted_key !== want.evicted_key) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%t: mismatch: expected hit %b value %h evicted %b key %h, %s",
                              $realtime, want.hit, want.read_value, want.evicted,
                              want.evicted_key, "see actual below");
                  if (error_count <= REPORT_LIMIT)
                     $display("%t:           actual   hit %b value %h evicted %b key %h",
                              $realtime, got.hit, got.read_value, got.evicted,
                              got.evicted_key);
               end
               if (want.hit) hit_count++;
               if (want.evicted) eviction_count++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_results.push_back(predict_cache_access(req_bus.cmd, req_bus.key,
                                                           req_bus.value,
                                                           req_bus.priority_req));
            if (req_bus.cmd == CMD_INSERT) insert_count++;
            else lookup_count++;
         end
      end
   end

   // The watchdog ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%t: no request or response moved for %0d cycles",
                  $realtime, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The receiver stalls at random, and holds off completely while a
   // pressure hold-off is running.
   initial rsp_bus.ready = 1'b0;

   always @(posedge clock) begin
      if (holding) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // The hold-off counts its own cycles so that the sender can carry on
   // offering requests meanwhile.
   initial begin
      forever begin
         @(start_hold);
         holding = 1'b1;
         repeat (PRESSURE_HOLD) @(posedge clock);
         holding = 1'b0;
      end
   end

   // Offers one request and returns at the edge that accepts it. Valid is
   // left high so that back-to-back requests need no second assignment.
   task automatic issue_request(logic cmd, logic [KEY_W-1:0] key,
                                logic [VALUE_W-1:0] value, logic prio);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.key <= key;
      req_bus.value <= value;
      req_bus.priority_req <= prio;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Withdraws the last request so that it is not taken a second time, then
   // lets the monitor log the final acceptance before waiting for responses.
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Corner cases on a freshly reset cache.
   task automatic test_directed();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      issue_request(CMD_LOOKUP, '0, VALUE_MAX, 1'b1);            // miss on empty cache
      issue_request(CMD_INSERT, KEY_MAX, '0, 1'b1);
      issue_request(CMD_INSERT, '0, VALUE_MAX, 1'b0);            // low segment was empty
      issue_request(CMD_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0);
      issue_request(CMD_LOOKUP, '0, '0, 1'b0);                   // low hit, moves forward
      issue_request(CMD_LOOKUP, '0, '0, 1'b1);                   // hit already at front
      issue_request(CMD_LOOKUP, KEY_MAX, VALUE_MAX, 1'b0);       // high hit at head
      issue_request(CMD_INSERT, KEY_MAX, 31'h0000_1234, 1'b0);   // present, high to low
      issue_request(CMD_LOOKUP, KEY_MAX, '0, 1'b0);
      issue_request(CMD_INSERT, 31'h5555_5555, 31'h0000_0001, 1'b1);
      issue_request(CMD_INSERT, '0, 31'h0000_0007, 1'b1);        // present, low to high
      issue_request(CMD_INSERT, '0, 31'h2AAA_AAAA, 1'b1);        // present, same segment
      issue_request(CMD_LOOKUP, '0, '0, 1'b0);
      issue_request(CMD_LOOKUP, 31'h7FFF_FFFE, '0, 1'b0);        // miss
      issue_request(CMD_INSERT, 31'h7FFF_FFFE, VALUE_MAX, 1'b1);
      issue_request(CMD_LOOKUP, 31'h7FFF_FFFE, '0, 1'b1);
      issue_request(CMD_LOOKUP, 31'h5555_5555, '0, 1'b0);
      issue_request(CMD_LOOKUP, 31'h2AAA_AAAA, '0, 1'b1);
      issue_request(CMD_INSERT, 31'h2AAA_AAAA, '0, 1'b0);
      issue_request(CMD_LOOKUP, KEY_MAX, '0, 1'b1);
      wait_for_drain();
   endtask

   // Enough fresh high-priority inserts to push every low entry out, after
   // which the tail of the list is a high entry and that one is evicted.
   task automatic test_all_high_eviction();
      logic [KEY_W-1:0] base;
      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      base = KEY_W'($urandom);
      for (int i = 0; i < CACHE_DEPTH + 8; i++)
         issue_request(CMD_INSERT, base + KEY_W'(i), VALUE_W'($urandom), 1'b1);
      for (int i = 0; i < 4; i++)
         issue_request(CMD_LOOKUP, base + KEY_W'(i * 9), '0, 1'b0);
      wait_for_drain();
   endtask

   // The receiver holds off while the sender keeps offering requests, so
   // a response is left waiting and the cache must stall its input.
   task automatic test_response_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      -> start_hold;
      for (int i = 0; i < 16; i++)
         issue_request(1'($urandom_range(1)), key_pool[$urandom_range(KEY_POOL_SIZE - 1)],
                       VALUE_W'($urandom), 1'($urandom_range(1)));
      wait_for_drain();
   endtask

   // Mostly traffic on a pool of keys a little larger than the cache, so
   // that hits, updates and evictions all happen often, with some lookups
   // and inserts of arbitrary keys as noise.
   task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                      int unsigned count);
      logic [KEY_W-1:0] key;
      logic             cmd;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
         else key = KEY_W'($urandom);
         cmd = ($urandom_range(99) < 55) ? CMD_INSERT : CMD_LOOKUP;
         issue_request(cmd, key, VALUE_W'($urandom), 1'($urandom_range(1)));
      end
      wait_for_drain();
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_LOOKUP;
      req_bus.key = '0;
      req_bus.value = '0;
      req_bus.priority_req = 1'b0;
      foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_all_high_eviction();
      test_response_backpressure();
      test_random_traffic(0, 0, 140);
      test_random_traffic(54, 0, 140);
      test_random_traffic(0, 54, 140);
      test_random_traffic(12, 12, 140);

      req_bus.valid <= 1'b0;
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         error_count++;
         $display("%0d responses never arrived", pending_results.size());
      end

      $display("Covered %0d inserts and %0d lookups: %0d hits and %0d evictions, %0d errors.",
               insert_count, lookup_count, hit_count, eviction_count, error_count);
      $display("Idling profiles: none, sender, receiver, both, and a %0d-cycle receiver hold-off.",
               PRESSURE_HOLD);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
